/* rtl/core/eur_pkg.sv */
// Shared constants for the Euler angle to rotation matrix unit.
`default_nettype none
package eur_pkg;
    // 2*pi in Q60
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;

    localparam int ANGLE_FIELD_W = 32;
    localparam int ELEM_FIELD_W  = 32;
    localparam int THR_W         = 10;
    localparam logic [THR_W-1:0] THR_RESET = 10'd4;

    localparam int APB_ADDR_W = 3;
    // register index, taken from the word address
    localparam logic REG_SNAP_THRESHOLD = 1'b0;
endpackage
`default_nettype wire

/* rtl/core/eur_sincos_lane.sv */
// One sine/cosine lane: octant reduction, pipelined Taylor series, snap and sign fix.
`default_nettype none
module eur_sincos_lane #(
    parameter int ANGLE_BITS        = 32,
    parameter int ELEMENT_FRAC_BITS = 30,
    parameter int TRIG_ITERATIONS   = 30
) (
    input  wire                                i_clk,
    input  wire                                i_ce,
    input  wire [ANGLE_BITS-1:0]               i_angle,
    input  wire [eur_pkg::THR_W-1:0]           i_thr,
    output logic signed [ELEMENT_FRAC_BITS+1:0] o_sin,
    output logic signed [ELEMENT_FRAC_BITS+1:0] o_cos
);
    import eur_pkg::*;

    localparam int F  = ELEMENT_FRAC_BITS;
    localparam int N  = TRIG_ITERATIONS;
    localparam int AB = ANGLE_BITS;
    localparam int EW = F + 2;
    localparam bit LAST_ODD = ((N - 1) % 2) == 1;

    // four 32x32 partial products of a 64x64 product: {hh, hl, lh, ll}
    function automatic logic [255:0] pp4(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ll, lh, hl, hh;
        ll = 64'(a[31:0]) * 64'(b[31:0]);
        lh = 64'(a[31:0]) * 64'(b[63:32]);
        hl = 64'(a[63:32]) * 64'(b[31:0]);
        hh = 64'(a[63:32]) * 64'(b[63:32]);
        return {hh, hl, lh, ll};
    endfunction

    function automatic logic [127:0] pp_sum(input logic [255:0] pp);
        return {64'd0, pp[63:0]} + {32'd0, pp[127:64], 32'd0} +
               {32'd0, pp[191:128], 32'd0} + {pp[255:192], 64'd0};
    endfunction

    function automatic logic [F:0] q62_to_el(input logic [63:0] v);
        logic [63:0] t;
        logic [63:0] one_el;
        one_el = 64'd1 << F;
        t = (v + (64'd1 << (61 - F))) >> (62 - F);
        if (t > one_el) begin
            t = one_el;
        end
        return t[F:0];
    endfunction

    // stage 0: octant reduction, partial products of the scaling to radians
    logic [2:0]    oct;
    logic [AB-4:0] resid;
    logic [AB-3:0] u;
    assign oct   = i_angle[AB-1:AB-3];
    assign resid = i_angle[AB-4:0];
    assign u     = oct[0] ? ({1'b1, {(AB-3){1'b0}}} - {1'b0, resid}) : {1'b0, resid};

    logic [255:0] r_pp_x;
    logic [2:0]   r_oct0;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pp_x <= pp4(64'(u) << (64 - AB), TWO_PI_Q60);
            r_oct0 <= oct;
        end
    end

    // stage 1: angle in radians, Q62
    logic [127:0] n_xsum;
    assign n_xsum = pp_sum(r_pp_x);

    logic [63:0] r_x;
    logic [2:0]  r_oct1;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x    <= n_xsum[125:62];
            r_oct1 <= r_oct0;
        end
    end

    // stage 2: partial products of x*x
    logic [255:0] r_pp_xx;
    logic [63:0]  r_x_d;
    logic [2:0]   r_oct2;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pp_xx <= pp4(r_x, r_x);
            r_x_d   <= r_x;
            r_oct2  <= r_oct1;
        end
    end

    // series state after term k: last terms, sums of the terms before them
    logic [127:0] n_xxsum;
    assign n_xxsum = pp_sum(r_pp_xx);

    logic [63:0] r_ts [N];
    logic [63:0] r_tc [N];
    logic [63:0] r_as [N];
    logic [63:0] r_ac [N];
    logic [63:0] r_x2 [N];
    logic [2:0]  r_oc [N];

    // stage 3
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x2[0] <= n_xxsum[125:62];
            r_ts[0] <= r_x_d;
            r_tc[0] <= ONE_Q62;
            r_as[0] <= '0;
            r_ac[0] <= '0;
            r_oc[0] <= r_oct2;
        end
    end

    // per term, four stages: product partials, product, quotient partials, quotient.
    // Division by the constant divisor is a reciprocal multiply, exact for p < 2^62.
    for (genvar k = 1; k < N; k++) begin : g_term
        localparam int D_S_INT = 4 * k * k + 2 * k;
        localparam int D_C_INT = 4 * k * k - 2 * k;
        localparam int L_S     = $clog2(D_S_INT);
        localparam int L_C     = $clog2(D_C_INT);
        localparam logic [127:0] D_S = 128'(D_S_INT);
        localparam logic [127:0] D_C = 128'(D_C_INT);
        localparam logic [63:0]  M_S = 64'(((128'd1 << (62 + L_S)) + D_S - 128'd1) / D_S);
        localparam logic [63:0]  M_C = 64'(((128'd1 << (62 + L_C)) + D_C - 128'd1) / D_C);
        localparam bit PREV_ODD = ((k - 1) % 2) == 1;

        // stage A: product partials; previous term folds into the sums
        logic [255:0] r_pa_s, r_pa_c;
        logic [63:0]  r_a_as, r_a_ac, r_a_x2;
        logic [2:0]   r_a_oc;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_pa_s <= pp4(r_ts[k-1], r_x2[k-1]);
                r_pa_c <= pp4(r_tc[k-1], r_x2[k-1]);
                if (PREV_ODD) begin
                    r_a_as <= r_as[k-1] - r_ts[k-1];
                    r_a_ac <= r_ac[k-1] - r_tc[k-1];
                end else begin
                    r_a_as <= r_as[k-1] + r_ts[k-1];
                    r_a_ac <= r_ac[k-1] + r_tc[k-1];
                end
                r_a_x2 <= r_x2[k-1];
                r_a_oc <= r_oc[k-1];
            end
        end

        // stage B: products >> 62
        logic [127:0] n_ps, n_pc;
        assign n_ps = pp_sum(r_pa_s);
        assign n_pc = pp_sum(r_pa_c);

        logic [63:0] r_b_ps, r_b_pc, r_b_as, r_b_ac, r_b_x2;
        logic [2:0]  r_b_oc;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_b_ps <= n_ps[125:62];
                r_b_pc <= n_pc[125:62];
                r_b_as <= r_a_as;
                r_b_ac <= r_a_ac;
                r_b_x2 <= r_a_x2;
                r_b_oc <= r_a_oc;
            end
        end

        // stage C: reciprocal partials
        logic [255:0] r_c_qs, r_c_qc;
        logic [63:0]  r_c_as, r_c_ac, r_c_x2;
        logic [2:0]   r_c_oc;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_c_qs <= pp4(r_b_ps, M_S);
                r_c_qc <= pp4(r_b_pc, M_C);
                r_c_as <= r_b_as;
                r_c_ac <= r_b_ac;
                r_c_x2 <= r_b_x2;
                r_c_oc <= r_b_oc;
            end
        end

        // stage D: quotients
        logic [127:0] n_qs, n_qc;
        assign n_qs = pp_sum(r_c_qs) >> (62 + L_S);
        assign n_qc = pp_sum(r_c_qc) >> (62 + L_C);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_ts[k] <= n_qs[63:0];
                r_tc[k] <= n_qc[63:0];
                r_as[k] <= r_c_as;
                r_ac[k] <= r_c_ac;
                r_x2[k] <= r_c_x2;
                r_oc[k] <= r_c_oc;
            end
        end
    end

    // last term into the sums
    logic [63:0] r_ss, r_cc;
    logic [2:0]  r_oc_fin;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (LAST_ODD) begin
                r_ss <= r_as[N-1] - r_ts[N-1];
                r_cc <= r_ac[N-1] - r_tc[N-1];
            end else begin
                r_ss <= r_as[N-1] + r_ts[N-1];
                r_cc <= r_ac[N-1] + r_tc[N-1];
            end
            r_oc_fin <= r_oc[N-1];
        end
    end

    // final: format, snap, octant swap, quadrant signs
    logic [F:0]           s_el, c_el, s_sn, c_sn, s_sw, c_sw;
    logic signed [EW-1:0] sp, cp, n_sin, n_cos;

    always_comb begin
        s_el = q62_to_el(r_ss);
        c_el = q62_to_el(r_cc);
        s_sn = (s_el <= (F+1)'(i_thr)) ? '0 : s_el;
        c_sn = (c_el <= (F+1)'(i_thr)) ? '0 : c_el;
        s_sw = r_oc_fin[0] ? c_sn : s_sn;
        c_sw = r_oc_fin[0] ? s_sn : c_sn;
        sp   = signed'({1'b0, s_sw});
        cp   = signed'({1'b0, c_sw});
        case (r_oc_fin[2:1])
            2'd0:    begin n_sin = sp;  n_cos = cp;  end
            2'd1:    begin n_sin = cp;  n_cos = -sp; end
            2'd2:    begin n_sin = -sp; n_cos = -cp; end
            default: begin n_sin = -cp; n_cos = sp;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/eur_matrix_merge.sv */
// Merge stage: combines the three lanes' sines and cosines into the nine matrix elements.
`default_nettype none
module eur_matrix_merge #(
    parameter int ELEMENT_FRAC_BITS = 30
) (
    input  wire                                 i_clk,
    input  wire                                 i_ce,
    input  wire                                 i_order,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_xs,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_xc,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_ys,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_yc,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_zs,
    input  wire signed [ELEMENT_FRAC_BITS+1:0]  i_zc,
    output logic [9*eur_pkg::ELEM_FIELD_W-1:0]  o_mat
);
    import eur_pkg::*;

    localparam int F  = ELEMENT_FRAC_BITS;
    localparam int EW = F + 2;
    localparam int SW = EW + 1;

    function automatic logic signed [EW-1:0] fmul(input logic signed [EW-1:0] a,
                                                  input logic signed [EW-1:0] b);
        logic            neg;
        logic [EW-1:0]   ua, ub, mag;
        logic [2*EW-1:0] p;
        neg = a[EW-1] ^ b[EW-1];
        ua  = a[EW-1] ? EW'(-a) : EW'(a);
        ub  = b[EW-1] ? EW'(-b) : EW'(b);
        p   = {{EW{1'b0}}, ua} * {{EW{1'b0}}, ub};
        p   = p + ({{(2*EW-1){1'b0}}, 1'b1} << (F - 1));
        mag = p[F+EW-1:F];
        return neg ? signed'(-mag) : signed'(mag);
    endfunction

    function automatic logic [ELEM_FIELD_W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] one_el;
        logic signed [SW-1:0] t;
        one_el = signed'({{(SW-1){1'b0}}, 1'b1} << F);
        t = v;
        if (t > one_el) begin
            t = one_el;
        end
        if (t < -one_el) begin
            t = -one_el;
        end
        return ELEM_FIELD_W'(t);
    endfunction

    // stage 1: two-factor products
    logic signed [EW-1:0] r1_zcyc, r1_zsxc, r1_zsxs, r1_zcxc, r1_zcxs, r1_zsyc;
    logic signed [EW-1:0] r1_ycxs, r1_ycxc, r1_zcys, r1_zsys, r1_xcys;
    logic signed [EW-1:0] r1_xs, r1_xc, r1_ys, r1_yc;
    logic                 r1_ord;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_zcyc <= fmul(i_zc, i_yc);
            r1_zsxc <= fmul(i_zs, i_xc);
            r1_zsxs <= fmul(i_zs, i_xs);
            r1_zcxc <= fmul(i_zc, i_xc);
            r1_zcxs <= fmul(i_zc, i_xs);
            r1_zsyc <= fmul(i_zs, i_yc);
            r1_ycxs <= fmul(i_yc, i_xs);
            r1_ycxc <= fmul(i_yc, i_xc);
            r1_zcys <= fmul(i_zc, i_ys);
            r1_zsys <= fmul(i_zs, i_ys);
            r1_xcys <= fmul(i_xc, i_ys);
            r1_xs   <= i_xs;
            r1_xc   <= i_xc;
            r1_ys   <= i_ys;
            r1_yc   <= i_yc;
            r1_ord  <= i_order;
        end
    end

    // stage 2: three-factor products, grouped left to right
    logic signed [EW-1:0] p1, p2, fa, fb;
    assign p1 = r1_ord ? r1_zsxs : r1_zcys;
    assign p2 = r1_ord ? r1_zcxs : r1_zsys;
    assign fa = r1_ord ? r1_ys : r1_xs;
    assign fb = r1_ord ? r1_yc : r1_xc;

    logic signed [EW-1:0] r2_t1a, r2_t1b, r2_t2a, r2_t2b;
    logic signed [EW-1:0] r2_zcyc, r2_zsxc, r2_zsxs, r2_zcxc, r2_zcxs, r2_zsyc;
    logic signed [EW-1:0] r2_ycxs, r2_ycxc, r2_zcys, r2_zsys, r2_xcys, r2_xs, r2_ys;
    logic                 r2_ord;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_t1a  <= fmul(p1, fa);
            r2_t1b  <= fmul(p1, fb);
            r2_t2a  <= fmul(p2, fa);
            r2_t2b  <= fmul(p2, fb);
            r2_zcyc <= r1_zcyc;
            r2_zsxc <= r1_zsxc;
            r2_zsxs <= r1_zsxs;
            r2_zcxc <= r1_zcxc;
            r2_zcxs <= r1_zcxs;
            r2_zsyc <= r1_zsyc;
            r2_ycxs <= r1_ycxs;
            r2_ycxc <= r1_ycxc;
            r2_zcys <= r1_zcys;
            r2_zsys <= r1_zsys;
            r2_xcys <= r1_xcys;
            r2_xs   <= r1_xs;
            r2_ys   <= r1_ys;
            r2_ord  <= r1_ord;
        end
    end

    // stage 3: sums and saturation
    logic signed [SW-1:0] e [9];
    always_comb begin
        if (!r2_ord) begin
            e[0] = SW'(r2_zcyc);
            e[1] = SW'(r2_zsxc) + SW'(r2_t1a);
            e[2] = SW'(r2_zsxs) - SW'(r2_t1b);
            e[3] = -SW'(r2_zsyc);
            e[4] = SW'(r2_zcxc) - SW'(r2_t2a);
            e[5] = SW'(r2_zcxs) + SW'(r2_t2b);
            e[6] = SW'(r2_ys);
            e[7] = -SW'(r2_ycxs);
            e[8] = SW'(r2_ycxc);
        end else begin
            e[0] = SW'(r2_zcyc) + SW'(r2_t1a);
            e[1] = SW'(r2_zsxc);
            e[2] = SW'(r2_t1b) - SW'(r2_zcys);
            e[3] = SW'(r2_t2a) - SW'(r2_zsyc);
            e[4] = SW'(r2_zcxc);
            e[5] = SW'(r2_zsys) + SW'(r2_t2b);
            e[6] = SW'(r2_xcys);
            e[7] = -SW'(r2_xs);
            e[8] = SW'(r2_ycxc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 9; i++) begin
                o_mat[i*ELEM_FIELD_W +: ELEM_FIELD_W] <= sat(e[i]);
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/euler_to_rotation_matrix_unit.sv */
// Top level: Euler angles to 3x3 rotation matrix, three trig lanes and a merge stage.
// Throughput: one item per cycle while the skid is empty; each Taylor term takes four
// pipelined stages of 32x32 parts. A two-entry output (head register plus skid) catches
// a head result that is not taken while the pipe moves; input then closes until it is taken.
// Reset (synchronous, active low) clears the valid pipeline and skid, and sets
// snap_threshold to 4; datapath registers are not reset.
`default_nettype none
module euler_to_rotation_matrix_unit #(
    parameter int ANGLE_BITS        = 32,
    parameter int ELEMENT_FRAC_BITS = 30,
    parameter int TRIG_ITERATIONS   = 30
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [95:0]   s_tdata,   // angle_x[31:0], angle_y[63:32], angle_z[95:64]
    input  wire [0:0]    s_tuser,   // rotation_order
    // output stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [287:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22, 32 bits each
    // configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [eur_pkg::APB_ADDR_W-1:0] paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import eur_pkg::*;

    localparam int F        = ELEMENT_FRAC_BITS;
    localparam int EW       = F + 2;
    localparam int LANE_LAT = 4 * TRIG_ITERATIONS + 2;
    localparam int LAT      = LANE_LAT + 3;
    localparam int OUT_W    = 9 * ELEM_FIELD_W;

    // ---------------- configuration register ----------------
    logic [THR_W-1:0] r_snap;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= THR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_SNAP_THRESHOLD) begin
            r_snap <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SNAP_THRESHOLD) begin
            prdata = 32'(r_snap);
        end
    end

    // ---------------- flow control ----------------
    // The whole pipe moves while the skid is empty; a head result that is not
    // taken on such a move drops into the skid.
    logic r_skid_vld;
    logic ce;
    logic [LAT-1:0] r_vld;
    logic head_vld;
    logic [OUT_W-1:0] head_data;
    logic [OUT_W-1:0] r_skid;

    assign ce       = !r_skid_vld;
    assign s_tready = ce;
    assign head_vld = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (ce) begin
                r_vld <= {r_vld[LAT-2:0], s_tvalid};
                if (head_vld && !m_tready) begin
                    r_skid_vld <= 1'b1;
                end
            end else if (m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce && head_vld && !m_tready) begin
            r_skid <= head_data;
        end
    end

    assign m_tvalid = r_skid_vld || head_vld;
    assign m_tdata  = r_skid_vld ? r_skid : head_data;

    // ---------------- order selector delay to the merge stage ----------------
    logic [LANE_LAT-1:0] r_ord;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ord <= {r_ord[LANE_LAT-2:0], s_tuser[0]};
        end
    end

    // ---------------- trig lanes ----------------
    logic signed [EW-1:0] xs, xc, ys, yc, zs, zc;

    eur_sincos_lane #(
        .ANGLE_BITS(ANGLE_BITS), .ELEMENT_FRAC_BITS(F), .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_lane_x (
        .i_clk(i_clk), .i_ce(ce),
        .i_angle(ANGLE_BITS'(s_tdata[0 +: ANGLE_FIELD_W])),
        .i_thr(r_snap), .o_sin(xs), .o_cos(xc)
    );

    eur_sincos_lane #(
        .ANGLE_BITS(ANGLE_BITS), .ELEMENT_FRAC_BITS(F), .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_lane_y (
        .i_clk(i_clk), .i_ce(ce),
        .i_angle(ANGLE_BITS'(s_tdata[ANGLE_FIELD_W +: ANGLE_FIELD_W])),
        .i_thr(r_snap), .o_sin(ys), .o_cos(yc)
    );

    eur_sincos_lane #(
        .ANGLE_BITS(ANGLE_BITS), .ELEMENT_FRAC_BITS(F), .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_lane_z (
        .i_clk(i_clk), .i_ce(ce),
        .i_angle(ANGLE_BITS'(s_tdata[2*ANGLE_FIELD_W +: ANGLE_FIELD_W])),
        .i_thr(r_snap), .o_sin(zs), .o_cos(zc)
    );

    // ---------------- merge ----------------
    eur_matrix_merge #(
        .ELEMENT_FRAC_BITS(F)
    ) u_merge (
        .i_clk(i_clk), .i_ce(ce), .i_order(r_ord[LANE_LAT-1]),
        .i_xs(xs), .i_xc(xc), .i_ys(ys), .i_yc(yc), .i_zs(zs), .i_zc(zc),
        .o_mat(head_data)
    );
endmodule
`default_nettype wire

/* tb/rotation_matrix_checker.sv */
// Checker: predicts rotation matrices from accepted angle triples and compares results.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire [95:0]   s_tdata,
    input  wire [0:0]    s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire [287:0]  m_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire          pready,
    input  wire [eur_pkg::APB_ADDR_W-1:0] paddr,
    input  wire [31:0]   pwdata,
    output int           o_fail_count,
    output int           o_pending
);
    import eur_pkg::*;

    localparam int FRAC = 30;
    localparam longint EL_ONE = 64'sd1 << FRAC;

    logic [THR_W-1:0] snap_thr;
    logic [287:0]     matrix_queue[$];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] q62_to_elem(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'h8000_0000) >> 32;
        if (r > 64'(EL_ONE)) r = 64'(EL_ONE);
        return r;
    endfunction

    task automatic trig(input logic [31:0] ang, input logic [THR_W-1:0] thr,
                        output longint sn, output longint cs);
        logic [2:0]  oct;
        logic [63:0] u, x, x2, ts, ss, tc, cc, s, c, t;
        oct = ang[31:29];
        u = oct[0] ? (64'd1 << 29) - {35'd0, ang[28:0]} : {35'd0, ang[28:0]};
        x  = mul_q62(u << 32, TWO_PI_Q60);
        x2 = mul_q62(x, x);
        ts = x; ss = x; tc = ONE_Q62; cc = ONE_Q62;
        for (int k = 1; k < 30; k++) begin
            ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
            tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
            if (k & 1) begin
                ss -= ts; cc -= tc;
            end else begin
                ss += ts; cc += tc;
            end
        end
        s = q62_to_elem(ss);
        c = q62_to_elem(cc);
        if (s <= 64'(thr)) s = 0;
        if (c <= 64'(thr)) c = 0;
        if (oct[0]) begin
            t = s; s = c; c = t;
        end
        case (oct[2:1])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    // magnitude product, rounded half away from zero, sign reapplied
    function automatic longint fx_mul(input longint a, input longint b);
        logic         neg;
        logic [63:0]  ua, ub;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = ({64'd0, ua} * {64'd0, ub} + 128'(1 << 29)) >> FRAC;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic [31:0] sat_elem(input longint v);
        if (v > EL_ONE) v = EL_ONE;
        if (v < -EL_ONE) v = -EL_ONE;
        return v[31:0];
    endfunction

    task automatic predict_matrix(input logic [95:0] d, input logic order,
                                  output logic [287:0] res);
        longint xs, xc, ys, yc, zs, zc;
        longint m[9];
        trig(d[31:0], snap_thr, xs, xc);
        trig(d[63:32], snap_thr, ys, yc);
        trig(d[95:64], snap_thr, zs, zc);
        if (!order) begin   // z-y-x
            m[0] = fx_mul(zc, yc);
            m[1] = fx_mul(zs, xc) + fx_mul(fx_mul(zc, ys), xs);
            m[2] = fx_mul(zs, xs) - fx_mul(fx_mul(zc, ys), xc);
            m[3] = fx_mul(-zs, yc);
            m[4] = fx_mul(zc, xc) - fx_mul(fx_mul(zs, ys), xs);
            m[5] = fx_mul(zc, xs) + fx_mul(fx_mul(zs, ys), xc);
            m[6] = ys;
            m[7] = fx_mul(-yc, xs);
            m[8] = fx_mul(yc, xc);
        end else begin      // z-x-y
            m[0] = fx_mul(yc, zc) + fx_mul(fx_mul(zs, xs), ys);
            m[1] = fx_mul(zs, xc);
            m[2] = fx_mul(-zc, ys) + fx_mul(fx_mul(zs, xs), yc);
            m[3] = fx_mul(-zs, yc) + fx_mul(fx_mul(zc, xs), ys);
            m[4] = fx_mul(xc, zc);
            m[5] = fx_mul(zs, ys) + fx_mul(fx_mul(zc, xs), yc);
            m[6] = fx_mul(xc, ys);
            m[7] = -xs;
            m[8] = fx_mul(yc, xc);
        end
        for (int i = 0; i < 9; i++) res[32*i +: 32] = sat_elem(m[i]);
    endtask

    initial begin
        o_fail_count = 0;
        snap_thr = THR_RESET;
    end

    assign o_pending = matrix_queue.size();

    always @(posedge i_clk) begin
        logic [287:0] want;
        if (!i_rst_n) begin
            snap_thr <= THR_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_SNAP_THRESHOLD)
                snap_thr <= pwdata[THR_W-1:0];
            if (s_tvalid && s_tready) begin
                predict_matrix(s_tdata, s_tuser[0], want);
                matrix_queue.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (matrix_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = matrix_queue.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                            o_fail_count++;
                            if (o_fail_count <= 10)
                                $display("element %0d%0d: expected %0d got %0d", i / 3, i % 3,
                                         $signed(want[32*i +: 32]),
                                         $signed(m_tdata[32*i +: 32]));
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench top: stimulus, flow control and verdict for the rotation matrix unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import eur_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    wire           s_tready;
    logic [95:0]   s_tdata = '0;   // angle_x, angle_y, angle_z from bit 0 up
    logic [0:0]    s_tuser = '0;   // rotation_order
    wire           m_tvalid;
    logic          m_tready = 1'b0;
    wire  [287:0]  m_tdata;        // m00 .. m22, 32 bits each, m00 lowest
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]   pwdata = '0;
    wire  [31:0]   prdata;
    wire           pready;
    int            fail_count, pending;
    int            stall_mode = 0;
    int            mode_left = 0;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    euler_to_rotation_matrix_unit dut (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rotation_matrix_checker chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall pattern switches between always-ready, coin-flip and mostly-stalled.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Setup then access phase; called right after a rising edge.
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold one item until its transfer; valid stays high into the next item.
    task automatic send_angles(input logic order, input logic [31:0] ax,
                               input logic [31:0] ay, input logic [31:0] az);
        s_tvalid <= 1'b1;
        s_tuser  <= order;
        s_tdata  <= {az, ay, ax};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drop_valid(input int gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // wait until every result is back, then let the pipeline empty out
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_angle();
        logic [31:0] a;
        case ($urandom_range(0, 7))
            0: a = {3'($urandom_range(0, 7)), 29'd0};                   // octant edge
            1: a = {3'($urandom_range(0, 7)), 29'd0} + $urandom_range(0, 40) - 20;
            2: a = $urandom_range(0, 4000);                             // near zero
            3: a = {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 40000) - 20000;
            default: a = $urandom;
        endcase
        return a;
    endfunction

    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < count) begin
                send_angles(1'($urandom_range(0, 1)), pick_angle(), pick_angle(), pick_angle());
                burst--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0) drop_valid($urandom_range(1, 8));
        end
        drop_valid(1);
    endtask

    initial begin
        logic [31:0] edges[12];
        edges = '{32'h0, 32'hFFFF_FFFF, 32'h2000_0000, 32'h1FFF_FFFF, 32'h4000_0000,
                  32'h6000_0001, 32'h8000_0000, 32'hA000_0000, 32'hC000_0000,
                  32'hE000_0000, 32'h0000_0100, 32'h3FFF_FF00};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: angle extremes and octant boundaries at the reset threshold, both orders.
        for (int i = 0; i < 12; i++)
            send_angles(i[0], edges[i], edges[(i + 5) % 12], edges[(i + 9) % 12]);
        send_angles(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_angles(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        drop_valid(1);
        drain();

        // Zero threshold, and a write whose upper bits must be dropped.
        reg_write(3'd0, 32'hFFFF_FC00);
        send_angles(1'b0, 32'h0000_0010, 32'h4000_0010, 32'h0);
        send_angles(1'b1, 32'h3FFF_FFF0, 32'h0, 32'h8000_0001);
        drop_valid(1);
        drain();

        // Maximum threshold snaps small sines; the write to the unused word is ignored.
        reg_write(3'd0, 32'hFFFF_FFFF);
        reg_write(3'd4, 32'h0000_0001);
        send_angles(1'b0, 32'h0001_0000, 32'h0001_5000, 32'hFFFF_0000);
        send_angles(1'b1, 32'h3FFF_0000, 32'h4000_9000, 32'h7FFF_F000);
        send_angles(1'b0, 32'hC000_4000, 32'h8000_8000, 32'h0000_0000);
        drop_valid(1);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       reg_write(3'd0, 32'd4);
                1:       reg_write(3'd0, 32'd0);
                2:       reg_write(3'd0, 32'd1023);
                default: reg_write(3'd0, $urandom);
            endcase
            random_phase(150);
            drain();
        end

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
